[src/dcc_pkg.sv]
// Shared types and constants for the DCC track signal generator.
// No dependencies; imported by every module of the block.
package dcc_pkg;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 6;

    localparam logic [CFG_IDX_W-1:0] REG_PREAMBLE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_CUTOUT   = 1'b1;

    localparam logic [5:0] PRE_RESET   = 6'd16;
    localparam logic [5:0] PRE_MIN     = 6'd10;
    localparam logic [5:0] PRE_MAX     = 6'd40;
    localparam logic [5:0] CUTOUT_SKIP = 6'd4;

    localparam logic [3:0] BIT_LAST  = 4'd8;
    localparam logic [3:0] BIT_COUNT = 4'd9;

    localparam logic [4:0] PH_START    = 5'd0;
    localparam logic [4:0] PH_CUT_ON   = 5'd1;
    localparam logic [4:0] PH_ONE_LOW  = 5'd2;
    localparam logic [4:0] PH_ONE_END  = 5'd3;
    localparam logic [4:0] PH_ZERO_LOW = 5'd4;
    localparam logic [4:0] PH_ZERO_END = 5'd7;
    localparam logic [4:0] PH_CUT_END  = 5'd16;

    localparam int         IDLE_LEN  = 3;
    localparam logic [7:0] IDLE_FILL = 8'hFF;
    localparam logic [7:0] IDLE_MID  = 8'h00;

    typedef struct packed {
        logic [13:0] address;
        logic [3:0]  kind;
        logic [7:0]  id;
    } tags_t;

    typedef struct packed {
        logic       nonempty;
        logic [7:0] cur_byte;
        logic [7:0] repeats;
        tags_t      tags;
    } queue_status_t;

    typedef struct packed {
        tags_t tags;
        logic  tag_valid;
        logic  cutout;
        logic  level;
    } tx_result_t;

    typedef struct packed {
        logic        load_accepted;
        logic [13:0] tag_address;
        logic [3:0]  tag_kind;
        logic [7:0]  tag_id;
        logic        tag_valid;
        logic        receive_enable;
        logic        cutout_active;
        logic        track_level;
    } out_word_t;

endpackage

[src/dcc_queue.sv]
// Packet queue: byte and descriptor memories, load path and dequeue.
// Depends on dcc_pkg.
module dcc_queue #(
    parameter int MAX_PACKET_BYTES = 8,
    parameter int QUEUE_SLOTS      = 8
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  load,
    input  logic [7:0]                            data_byte,
    input  logic                                  last_byte,
    input  logic [7:0]                            repeat_count,
    input  dcc_pkg::tags_t                        load_tags,
    output logic                                  load_accepted,
    input  logic                                  deq,
    input  logic [$clog2(MAX_PACKET_BYTES)-1:0]   byte_index,
    output dcc_pkg::queue_status_t                status,
    output logic [$clog2(MAX_PACKET_BYTES+1)-1:0] head_len
);
    import dcc_pkg::*;

    localparam int PS   = QUEUE_SLOTS + 1;
    localparam int SW   = $clog2(PS);
    localparam int IW   = $clog2(MAX_PACKET_BYTES);
    localparam int LW   = $clog2(MAX_PACKET_BYTES + 1);
    localparam int CNTW = $clog2(QUEUE_SLOTS + 1);
    localparam int BD   = PS * (2 ** IW);
    localparam int MW   = LW + 8 + $bits(tags_t);

    logic [7:0]    byte_mem [BD];
    logic [MW-1:0] meta_mem [PS];

    logic [SW-1:0]   head_reg, head_next;
    logic [SW-1:0]   send_slot_reg, send_slot_next;
    logic [CNTW-1:0] count_reg, count_next;
    logic [LW-1:0]   cursor_reg, cursor_next;
    logic            dropping_reg, dropping_next;
    logic [7:0]      byte_rd_reg;
    logic [MW-1:0]   meta_rd_reg;

    logic [SW:0]     tail_sum;
    logic [SW-1:0]   tail;
    logic            byte_we, meta_we;
    logic [MW-1:0]   meta_wdata;
    logic [LW-1:0]   cursor_inc;

    always_comb begin
        tail_sum = {1'b0, head_reg} + (SW+1)'(count_reg);
        if (tail_sum >= (SW+1)'(PS)) begin
            tail = SW'(tail_sum - (SW+1)'(PS));
        end else begin
            tail = tail_sum[SW-1:0];
        end
    end

    always_comb begin
        head_next      = head_reg;
        send_slot_next = send_slot_reg;
        count_next     = count_reg;
        cursor_next    = cursor_reg;
        dropping_next  = dropping_reg;
        byte_we        = 1'b0;
        meta_we        = 1'b0;
        load_accepted  = 1'b0;
        cursor_inc     = cursor_reg;
        if (cursor_reg < LW'(MAX_PACKET_BYTES)) begin
            cursor_inc = cursor_reg + LW'(1);
        end
        meta_wdata = {cursor_inc, repeat_count, load_tags};
        if (load) begin
            if (dropping_reg || (cursor_reg == '0 && count_reg >= CNTW'(QUEUE_SLOTS))) begin
                dropping_next = !last_byte;
                if (last_byte) begin
                    cursor_next = '0;
                end
            end else begin
                if (cursor_reg < LW'(MAX_PACKET_BYTES)) begin
                    byte_we       = 1'b1;
                    load_accepted = 1'b1;
                end
                cursor_next = cursor_inc;
                if (last_byte) begin
                    meta_we     = 1'b1;
                    count_next  = count_reg + CNTW'(1);
                    cursor_next = '0;
                end
            end
        end
        if (deq) begin
            send_slot_next = head_reg;
            head_next      = (head_reg == SW'(PS - 1)) ? '0 : head_reg + SW'(1);
            count_next     = count_reg - CNTW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg      <= '0;
            send_slot_reg <= '0;
            count_reg     <= '0;
            cursor_reg    <= '0;
            dropping_reg  <= 1'b0;
        end else begin
            head_reg      <= head_next;
            send_slot_reg <= send_slot_next;
            count_reg     <= count_next;
            cursor_reg    <= cursor_next;
            dropping_reg  <= dropping_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (byte_we) begin
            byte_mem[{tail, cursor_reg[IW-1:0]}] <= data_byte;
        end
        byte_rd_reg <= byte_mem[{send_slot_reg, byte_index}];
    end

    // forward a descriptor written to the slot being read
    always_ff @(posedge aclk) begin
        if (meta_we) begin
            meta_mem[tail] <= meta_wdata;
        end
        if (meta_we && tail == head_reg) begin
            meta_rd_reg <= meta_wdata;
        end else begin
            meta_rd_reg <= meta_mem[head_reg];
        end
    end

    assign status.nonempty = (count_reg != '0);
    assign status.cur_byte = byte_rd_reg;
    assign status.repeats  = meta_rd_reg[$bits(tags_t) +: 8];
    assign status.tags     = meta_rd_reg[$bits(tags_t)-1:0];
    assign head_len        = meta_rd_reg[MW-1 -: LW];

endmodule

[src/dcc_tx.sv]
// Waveform sequencer: tick phases, preamble, bit and byte position, cutout.
// Depends on dcc_pkg; bytes and descriptors come from dcc_queue.
module dcc_tx #(
    parameter int MAX_PACKET_BYTES = 8
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  tick,
    input  logic [5:0]                            preamble_bits,
    input  logic                                  cutout_enable,
    input  dcc_pkg::queue_status_t                status,
    input  logic [$clog2(MAX_PACKET_BYTES+1)-1:0] head_len,
    output logic                                  deq,
    output logic [$clog2(MAX_PACKET_BYTES)-1:0]   byte_index,
    output dcc_pkg::tx_result_t                   result
);
    import dcc_pkg::*;

    localparam int IW = $clog2(MAX_PACKET_BYTES);
    localparam int LW = $clog2(MAX_PACKET_BYTES + 1);

    logic [4:0]    phase_reg, phase_next;
    logic          bit_reg, bit_next;
    logic          level_reg, level_next;
    logic          pend_reg, pend_next;
    logic          now_reg, now_next;
    logic [5:0]    pre_left_reg, pre_left_next;
    logic [3:0]    bit_idx_reg, bit_idx_next;
    logic [IW-1:0] byte_idx_reg, byte_idx_next;
    logic          idle_reg, idle_next;
    logic [LW-1:0] len_reg, len_next;
    logic [7:0]    rep_reg, rep_next;
    tags_t         tags_reg, tags_next;

    logic [5:0]    pre_eff;
    logic [7:0]    cur_byte;
    logic [3:0]    bit_sel;
    logic [3:0]    bit_idx_inc;
    logic [LW-1:0] byte_idx_inc;
    logic          tag_valid;

    always_comb begin
        if (preamble_bits < PRE_MIN) begin
            pre_eff = PRE_MIN;
        end else if (preamble_bits > PRE_MAX) begin
            pre_eff = PRE_MAX;
        end else begin
            pre_eff = preamble_bits;
        end
    end

    always_comb begin
        if (idle_reg) begin
            cur_byte = (byte_idx_reg == IW'(1)) ? IDLE_MID : IDLE_FILL;
        end else begin
            cur_byte = status.cur_byte;
        end
        bit_sel      = BIT_LAST - bit_idx_reg;
        bit_idx_inc  = bit_idx_reg + 4'd1;
        byte_idx_inc = LW'(byte_idx_reg) + LW'(1);
    end

    always_comb begin
        phase_next    = phase_reg;
        bit_next      = bit_reg;
        level_next    = level_reg;
        pend_next     = pend_reg;
        now_next      = now_reg;
        pre_left_next = pre_left_reg;
        bit_idx_next  = bit_idx_reg;
        byte_idx_next = byte_idx_reg;
        idle_next     = idle_reg;
        len_next      = len_reg;
        rep_next      = rep_reg;
        tags_next     = tags_reg;
        tag_valid     = 1'b0;
        deq           = 1'b0;
        if (tick) begin
            case (phase_reg)
                PH_START: begin
                    level_next = 1'b1;
                    phase_next = PH_CUT_ON;
                    if (pre_left_reg != '0) begin
                        bit_next = 1'b1;
                        if (pre_left_reg == pre_eff && cutout_enable) begin
                            pend_next     = 1'b1;
                            pre_left_next = pre_left_reg - CUTOUT_SKIP;
                        end else begin
                            pre_left_next = pre_left_reg - 6'd1;
                        end
                    end else begin
                        if (bit_idx_reg == '0 || bit_idx_reg > BIT_LAST) begin
                            bit_next = 1'b0;
                        end else begin
                            bit_next = cur_byte[bit_sel[2:0]];
                        end
                        bit_idx_next = bit_idx_inc;
                        if (bit_idx_inc >= BIT_COUNT) begin
                            bit_idx_next = '0;
                            if (byte_idx_inc >= len_reg) begin
                                byte_idx_next = '0;
                                pre_left_next = pre_eff + 6'd1;
                                if (rep_reg != '0) begin
                                    rep_next = rep_reg - 8'd1;
                                end else if (status.nonempty) begin
                                    deq       = 1'b1;
                                    idle_next = 1'b0;
                                    len_next  = head_len;
                                    rep_next  = status.repeats;
                                    tags_next = status.tags;
                                end else begin
                                    idle_next = 1'b1;
                                    len_next  = LW'(IDLE_LEN);
                                    rep_next  = '0;
                                end
                            end else begin
                                byte_idx_next = byte_idx_inc[IW-1:0];
                            end
                        end
                    end
                end
                PH_CUT_ON: begin
                    if (pend_reg) begin
                        now_next = 1'b1;
                    end
                    phase_next = PH_ONE_LOW;
                end
                PH_ONE_LOW: begin
                    if (bit_reg && !pend_reg) begin
                        level_next = 1'b0;
                    end
                    phase_next = PH_ONE_END;
                end
                PH_ONE_END: begin
                    phase_next = (bit_reg && !pend_reg) ? PH_START : PH_ZERO_LOW;
                end
                PH_ZERO_LOW: begin
                    if (!pend_reg) begin
                        level_next = 1'b0;
                    end
                    phase_next = phase_reg + 5'd1;
                end
                PH_ZERO_END: begin
                    phase_next = pend_reg ? phase_reg + 5'd1 : PH_START;
                end
                PH_CUT_END: begin
                    now_next   = 1'b0;
                    level_next = 1'b0;
                    pend_next  = 1'b0;
                    phase_next = PH_START;
                    tag_valid  = 1'b1;
                end
                default: begin
                    phase_next = (phase_reg < PH_CUT_END) ? phase_reg + 5'd1 : PH_START;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_START;
            bit_reg      <= 1'b0;
            level_reg    <= 1'b0;
            pend_reg     <= 1'b0;
            now_reg      <= 1'b0;
            pre_left_reg <= '0;
            bit_idx_reg  <= '0;
            byte_idx_reg <= '0;
            idle_reg     <= 1'b1;
            len_reg      <= LW'(IDLE_LEN);
            rep_reg      <= '0;
            tags_reg     <= '0;
        end else begin
            phase_reg    <= phase_next;
            bit_reg      <= bit_next;
            level_reg    <= level_next;
            pend_reg     <= pend_next;
            now_reg      <= now_next;
            pre_left_reg <= pre_left_next;
            bit_idx_reg  <= bit_idx_next;
            byte_idx_reg <= byte_idx_next;
            idle_reg     <= idle_next;
            len_reg      <= len_next;
            rep_reg      <= rep_next;
            tags_reg     <= tags_next;
        end
    end

    assign byte_index       = byte_idx_reg;
    assign result.level     = level_next;
    assign result.cutout    = now_next;
    assign result.tag_valid = tag_valid;
    assign result.tags      = tag_valid ? tags_reg : '0;

endmodule

[src/dcc_out_buf.sv]
// Two-entry output stage: output register plus skid register.
// Depends on dcc_pkg for the result word type.
module dcc_out_buf (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  dcc_pkg::out_word_t in_word,
    output logic               out_valid,
    input  logic               out_ready,
    output dcc_pkg::out_word_t out_word
);
    import dcc_pkg::*;

    logic      out_valid_reg, out_valid_next;
    logic      skid_valid_reg, skid_valid_next;
    out_word_t out_word_reg, out_word_next;
    out_word_t skid_word_reg, skid_word_next;
    logic      pop, push;

    assign in_ready = !skid_valid_reg;
    assign push     = in_valid && in_ready;
    assign pop      = out_valid_reg && out_ready;

    always_comb begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_word_next   = out_word_reg;
        skid_word_next  = skid_word_reg;
        if (skid_valid_reg) begin
            if (pop) begin
                out_word_next   = skid_word_reg;
                skid_valid_next = 1'b0;
            end
        end else if (push) begin
            if (!out_valid_reg || pop) begin
                out_word_next  = in_word;
                out_valid_next = 1'b1;
            end else begin
                skid_word_next  = in_word;
                skid_valid_next = 1'b1;
            end
        end else if (pop) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_word_reg  <= out_word_next;
        skid_word_reg <= skid_word_next;
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

endmodule

[src/dcc_track_signal_generator_core.sv]
// DCC track signal generator top level: config registers, queue, sequencer, output.
// Depends on dcc_pkg, dcc_queue, dcc_tx and dcc_out_buf.
// Result words are registered in the output stage. Throughput: one word per cycle
// unless m_tready stalls; the two-entry output stage keeps s_tready high while one
// result waits. Queue bytes and descriptors sit in memories with registered reads.
// Reset: synchronous, active low; the idle packet starts at once, queue empty.
module dcc_track_signal_generator_core #(
    parameter int MAX_PACKET_BYTES = 8,
    parameter int QUEUE_SLOTS      = 8
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // data_byte[7:0], repeat_count[15:8], packet_tag[23:16], packet_kind[27:24],
    // decoder_address[41:28], zero fill[47:42]
    input  logic [47:0]                    s_tdata,
    // command[0]
    input  logic                           s_tuser,
    input  logic                           s_tlast,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // track_level[0], cutout_active[1], receive_enable[2], tag_valid[3],
    // tag_id[11:4], tag_kind[15:12], tag_address[29:16], load_accepted[30], zero[31]
    output logic [31:0]                    m_tdata,
    input  logic                           cfg_wr_en,
    input  logic [dcc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [dcc_pkg::CFG_DATA_W-1:0] cfg_wr_data
);
    import dcc_pkg::*;

    localparam int IW = $clog2(MAX_PACKET_BYTES);
    localparam int LW = $clog2(MAX_PACKET_BYTES + 1);

    logic [5:0] preamble_reg;
    logic       cutout_en_reg;

    logic          accept, load, tick;
    tags_t         load_tags;
    logic          load_accepted;
    logic          deq;
    logic [IW-1:0] byte_index;
    logic [LW-1:0] head_len;
    queue_status_t status;
    tx_result_t    tx_res;
    out_word_t     in_word, out_word;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            preamble_reg  <= PRE_RESET;
            cutout_en_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_PREAMBLE: preamble_reg  <= cfg_wr_data[5:0];
                REG_CUTOUT:   cutout_en_reg <= cfg_wr_data[0];
                default: ;
            endcase
        end
    end

    assign accept            = s_tvalid && s_tready;
    assign load              = accept && s_tuser;
    assign tick              = accept && !s_tuser;
    assign load_tags.id      = s_tdata[23:16];
    assign load_tags.kind    = s_tdata[27:24];
    assign load_tags.address = s_tdata[41:28];

    dcc_queue #(
        .MAX_PACKET_BYTES(MAX_PACKET_BYTES),
        .QUEUE_SLOTS     (QUEUE_SLOTS)
    ) u_queue (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .load         (load),
        .data_byte    (s_tdata[7:0]),
        .last_byte    (s_tlast),
        .repeat_count (s_tdata[15:8]),
        .load_tags    (load_tags),
        .load_accepted(load_accepted),
        .deq          (deq),
        .byte_index   (byte_index),
        .status       (status),
        .head_len     (head_len)
    );

    dcc_tx #(
        .MAX_PACKET_BYTES(MAX_PACKET_BYTES)
    ) u_tx (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .tick         (tick),
        .preamble_bits(preamble_reg),
        .cutout_enable(cutout_en_reg),
        .status       (status),
        .head_len     (head_len),
        .deq          (deq),
        .byte_index   (byte_index),
        .result       (tx_res)
    );

    assign in_word.track_level    = tx_res.level;
    assign in_word.cutout_active  = tx_res.cutout;
    assign in_word.receive_enable = tx_res.cutout;
    assign in_word.tag_valid      = tx_res.tag_valid;
    assign in_word.tag_id         = tx_res.tags.id;
    assign in_word.tag_kind       = tx_res.tags.kind;
    assign in_word.tag_address    = tx_res.tags.address;
    assign in_word.load_accepted  = load_accepted;

    dcc_out_buf u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_word  (in_word),
        .out_valid(m_tvalid),
        .out_ready(m_tready),
        .out_word (out_word)
    );

    assign m_tdata = {1'b0, out_word};

endmodule
